/* design/rts_pkg.sv */
package rts_pkg;

  localparam int CFG_W           = 12;
  localparam int COORD_W         = 10;
  localparam int REG_IDX_W       = 3;
  localparam int SAMPLE_BITS_DEF = 12;

  // Conversion framing in ticks: eight command bits take two ticks each,
  // then one busy clock, then the read clocks.
  localparam int CMD_PHASE_TICKS = 16;
  localparam int READ_START      = 18;

  localparam logic [7:0] CMD_READ_Y = 8'h90;
  localparam logic [7:0] CMD_READ_X = 8'hD0;

  localparam logic [COORD_W-1:0] COORD_MAX = 10'd1023;

  localparam logic [REG_IDX_W-1:0] REG_CAL_X_MIN   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CAL_X_MAX   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CAL_Y_MIN   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CAL_Y_MAX   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_AGREE_LIMIT = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SCREEN_W    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SCREEN_H    = 3'd6;

  localparam logic [CFG_W-1:0]   RST_CAL_X_MIN   = 12'd0;
  localparam logic [CFG_W-1:0]   RST_CAL_X_MAX   = 12'd4095;
  localparam logic [CFG_W-1:0]   RST_CAL_Y_MIN   = 12'd0;
  localparam logic [CFG_W-1:0]   RST_CAL_Y_MAX   = 12'd4095;
  localparam logic [CFG_W-1:0]   RST_AGREE_LIMIT = 12'd10;
  localparam logic [COORD_W-1:0] RST_SCREEN_W    = 10'd240;
  localparam logic [COORD_W-1:0] RST_SCREEN_H    = 10'd320;

  typedef struct packed {
    logic pen_low;
    logic adc_dout;
  } rts_in_t;

  typedef struct packed {
    logic               chip_select_n;
    logic               serial_clock;
    logic               serial_din;
    logic               point_done;
    logic               point_valid;
    logic [COORD_W-1:0] screen_x;
    logic [COORD_W-1:0] screen_y;
  } rts_out_t;

  typedef struct packed {
    logic cs_n;
    logic sclk;
    logic din;
  } rts_pins_t;

  typedef struct packed {
    logic [CFG_W-1:0]   x_min;
    logic [CFG_W-1:0]   x_max;
    logic [CFG_W-1:0]   y_min;
    logic [CFG_W-1:0]   y_max;
    logic [CFG_W-1:0]   agree_limit;
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] height;
  } rts_cfg_t;

  // One microcode word per conversion tick
  typedef struct packed {
    logic cs_n;
    logic sclk;
    logic din_we;
    logic din;
    logic shift;
    logic store;
    logic store_x;
    logic last;
  } rts_ctrl_t;

  typedef struct packed {
    logic busy;
    logic fin;
    logic valid;
  } rts_scl_stat_t;

  // Control word for conversion tick c, p ticks per command.
  function automatic rts_ctrl_t rts_ucode_word(input int c, input int p);
    rts_ctrl_t  w;
    int         k;
    logic [7:0] cmd;
    w   = '0;
    k   = c;
    cmd = CMD_READ_Y;
    if (c == 2 * p) begin
      // release select, take last X bit
      w.cs_n    = 1'b1;
      w.shift   = 1'b1;
      w.store   = 1'b1;
      w.store_x = 1'b1;
      w.last    = 1'b1;
    end else begin
      if (c >= p) begin
        k   = c - p;
        cmd = CMD_READ_X;
      end
      if (k < CMD_PHASE_TICKS) begin
        if ((k & 1) == 0) begin
          w.din_we = 1'b1;
          w.din    = cmd[7 - (k >> 1)];
        end else begin
          w.sclk = 1'b1;
        end
      end else begin
        w.sclk = ((k & 1) == 0);
      end
      if (k >= READ_START + 2 && (k & 1) == 0) w.shift = 1'b1;
      // last Y bit lands on the first tick of the X command
      if (c == p) begin
        w.shift = 1'b1;
        w.store = 1'b1;
      end
    end
    return w;
  endfunction

endpackage

/* design/rts_divider.sv */
module rts_divider import rts_pkg::*; #(
  parameter int NUM_W = 22,
  parameter int DEN_W = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [DEN_W-1:0] rem_nxt;

  // restoring, one quotient bit per cycle
  assign trial   = {rem_r, quo_r[NUM_W-1]};
  assign ge      = (trial >= {1'b0, den});
  assign diff    = trial - {1'b0, den};
  assign rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(NUM_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
    end else if (run_r) begin
      quo_r <= {quo_r[NUM_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

/* design/rts_sequencer.sv */
module rts_sequencer import rts_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            tick,
  input  rts_in_t                         in_data,
  output rts_pins_t                       pins,
  output rts_pins_t                       pins_nxt,
  output logic                            acq_end,
  output logic [3:0][SAMPLE_BITS-1:0]     raw
);

  localparam int CMD_TICKS = READ_START + 2 * SAMPLE_BITS;
  localparam int CONV_LAST = 2 * CMD_TICKS;
  localparam int UPC_W     = $clog2(CONV_LAST + 1);

  rts_ctrl_t rom [CONV_LAST+1];

  for (genvar gi = 0; gi <= CONV_LAST; gi++) begin : g_rom
    assign rom[gi] = rts_ucode_word(gi, CMD_TICKS);
  end

  logic [UPC_W-1:0]               upc_r;
  logic                           conv_r;
  logic                           busy_r;
  logic [SAMPLE_BITS-1:0]         shift_r;
  logic [SAMPLE_BITS-1:0]         shift_nxt;
  logic [3:0][SAMPLE_BITS-1:0]    raw_r;
  rts_pins_t                      pins_r;
  rts_ctrl_t                      cw;
  logic                           active;

  assign cw        = rom[upc_r];
  // idle sequencer starts on the tick that sees the pen down
  assign active    = tick && (busy_r || !in_data.pen_low);
  assign shift_nxt = {shift_r[SAMPLE_BITS-2:0], in_data.adc_dout};

  always_comb begin
    pins_nxt = pins_r;
    if (active) begin
      pins_nxt.cs_n = cw.cs_n;
      pins_nxt.sclk = cw.sclk;
      if (cw.din_we) pins_nxt.din = cw.din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r   <= '0;
      conv_r  <= 1'b0;
      busy_r  <= 1'b0;
      shift_r <= '0;
      pins_r  <= '{cs_n: 1'b1, sclk: 1'b0, din: 1'b1};
    end else if (active) begin
      pins_r <= pins_nxt;
      if (cw.shift) begin
        if (cw.store) shift_r <= '0;
        else          shift_r <= shift_nxt;
      end
      if (cw.last) begin
        // jump back for the second conversion, or stop
        upc_r  <= '0;
        conv_r <= ~conv_r;
        busy_r <= ~conv_r;
      end else begin
        upc_r  <= upc_r + 1'b1;
        busy_r <= 1'b1;
      end
    end
  end

  // Y1, X1, Y2, X2
  always_ff @(posedge clk) begin
    if (active && cw.shift && cw.store) raw_r[{conv_r, cw.store_x}] <= shift_nxt;
  end

  assign acq_end = active && cw.last && conv_r;
  assign pins    = pins_r;
  assign raw     = raw_r;

endmodule

/* design/rts_scaler.sv */
module rts_scaler import rts_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        out_free,
  input  rts_cfg_t                    cfg,
  input  logic [3:0][SAMPLE_BITS-1:0] raw,
  output rts_scl_stat_t               stat,
  output logic [COORD_W-1:0]          screen_x,
  output logic [COORD_W-1:0]          screen_y
);

  localparam int CW = (SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W;
  localparam int NW = COORD_W + CW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]             state_r;
  logic                   axis_r;
  logic                   valid_r;
  logic [SAMPLE_BITS-1:0] avg_x_r;
  logic [SAMPLE_BITS-1:0] avg_y_r;
  logic [NW-1:0]          num_r;
  logic [CFG_W-1:0]       den_r;
  logic [COORD_W-1:0]     lp_x_r;
  logic [COORD_W-1:0]     lp_y_r;

  logic [SAMPLE_BITS-1:0] y1, x1, y2, x2;
  logic [SAMPLE_BITS-1:0] dx, dy;
  logic [SAMPLE_BITS:0]   sum_x, sum_y;
  logic [SAMPLE_BITS-1:0] ax, ay;
  logic                   agree, above, accept;

  logic [SAMPLE_BITS-1:0] sel_avg;
  logic [CFG_W-1:0]       sel_lo, sel_hi;
  logic [COORD_W-1:0]     sel_size;
  logic                   span_ok;
  logic [CW-1:0]          offs;
  logic [NW-1:0]          prod;

  logic                   div_done;
  logic [NW-1:0]          quot;
  logic [COORD_W-1:0]     q_sat;

  assign y1 = raw[0];
  assign x1 = raw[1];
  assign y2 = raw[2];
  assign x2 = raw[3];

  assign dx     = (x1 > x2) ? x1 - x2 : x2 - x1;
  assign dy     = (y1 > y2) ? y1 - y2 : y2 - y1;
  assign sum_x  = {1'b0, x1} + {1'b0, x2};
  assign sum_y  = {1'b0, y1} + {1'b0, y2};
  assign ax     = sum_x[SAMPLE_BITS:1];
  assign ay     = sum_y[SAMPLE_BITS:1];
  assign agree  = (CW'(dx) < CW'(cfg.agree_limit)) && (CW'(dy) < CW'(cfg.agree_limit));
  assign above  = (CW'(ax) > CW'(cfg.x_min)) && (CW'(ay) > CW'(cfg.y_min));
  assign accept = agree && above;

  assign sel_avg  = axis_r ? avg_y_r    : avg_x_r;
  assign sel_lo   = axis_r ? cfg.y_min  : cfg.x_min;
  assign sel_hi   = axis_r ? cfg.y_max  : cfg.x_max;
  assign sel_size = axis_r ? cfg.height : cfg.width;
  assign span_ok  = (sel_hi > sel_lo);
  // average is known to lie above the minimum here
  assign offs     = CW'(sel_avg) - CW'(sel_lo);
  assign prod     = NW'(sel_size) * NW'(offs);

  rts_divider #(
    .NUM_W (NW),
    .DEN_W (CFG_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_START),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quot  (quot)
  );

  assign q_sat = (|quot[NW-1:COORD_W]) ? COORD_MAX : quot[COORD_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r  <= 1'b0;
      valid_r <= 1'b0;
      lp_x_r  <= '0;
      lp_y_r  <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) state_r <= S_CHECK;
        end
        S_CHECK: begin
          valid_r <= accept;
          axis_r  <= 1'b0;
          state_r <= accept ? S_MUL : S_DONE;
        end
        S_MUL: begin
          if (span_ok) begin
            state_r <= S_START;
          end else begin
            // flat calibration span saturates
            if (axis_r) begin
              lp_y_r  <= COORD_MAX;
              state_r <= S_DONE;
            end else begin
              lp_x_r <= COORD_MAX;
              axis_r <= 1'b1;
            end
          end
        end
        S_START: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            if (axis_r) begin
              lp_y_r  <= q_sat;
              state_r <= S_DONE;
            end else begin
              lp_x_r  <= q_sat;
              axis_r  <= 1'b1;
              state_r <= S_MUL;
            end
          end
        end
        S_DONE: begin
          if (out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CHECK) begin
      avg_x_r <= ax;
      avg_y_r <= ay;
    end
    if (state_r == S_MUL) begin
      num_r <= prod;
      den_r <= sel_hi - sel_lo;
    end
  end

  assign stat.busy  = (state_r != S_IDLE);
  assign stat.fin   = (state_r == S_DONE);
  assign stat.valid = valid_r;
  assign screen_x   = lp_x_r;
  assign screen_y   = lp_y_r;

endmodule

/* design/resistive_touch_sampler_core.sv */
// channel   direction  payload     transfers
// in_       input      rts_in_t    one pin sample per tick
// out_      output     rts_out_t   pin levels and point status, one per tick
// cfg_      input      index/data  calibration and scale registers
//
// Each input transaction is one tick; the result sits in an output register, and
// the next tick is taken only when that register is empty or being taken.
// The last tick of an acquisition runs the check and the shared one-bit-a-cycle
// divider for both axes, X first and then Y.
// Reset (rst_n low, synchronous) returns the sequencer to idle and the registers
// to their defaults; raw samples hold no defined value until an acquisition.
// in_ready drops while the output register is full and not taken, and during scaling.
module resistive_touch_sampler_core import rts_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rts_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rts_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  rts_cfg_t                    cfg_r;
  rts_pins_t                   pins;
  rts_pins_t                   pins_nxt;
  logic                        acq_end;
  logic [3:0][SAMPLE_BITS-1:0] raw;
  rts_scl_stat_t               stat;
  logic [COORD_W-1:0]          screen_x;
  logic [COORD_W-1:0]          screen_y;

  logic                        out_valid_r;
  rts_out_t                    out_data_r;
  rts_out_t                    out_data_nxt;
  logic                        out_free;
  logic                        tick;
  logic                        load_tick;
  logic                        load_fin;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_min       <= RST_CAL_X_MIN;
      cfg_r.x_max       <= RST_CAL_X_MAX;
      cfg_r.y_min       <= RST_CAL_Y_MIN;
      cfg_r.y_max       <= RST_CAL_Y_MAX;
      cfg_r.agree_limit <= RST_AGREE_LIMIT;
      cfg_r.width       <= RST_SCREEN_W;
      cfg_r.height      <= RST_SCREEN_H;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CAL_X_MIN:   cfg_r.x_min       <= cfg_data;
        REG_CAL_X_MAX:   cfg_r.x_max       <= cfg_data;
        REG_CAL_Y_MIN:   cfg_r.y_min       <= cfg_data;
        REG_CAL_Y_MAX:   cfg_r.y_max       <= cfg_data;
        REG_AGREE_LIMIT: cfg_r.agree_limit <= cfg_data;
        REG_SCREEN_W:    cfg_r.width       <= cfg_data[COORD_W-1:0];
        REG_SCREEN_H:    cfg_r.height      <= cfg_data[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = !stat.busy && out_free;
  assign tick     = in_valid && in_ready;

  rts_sequencer #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .tick     (tick),
    .in_data  (in_data),
    .pins     (pins),
    .pins_nxt (pins_nxt),
    .acq_end  (acq_end),
    .raw      (raw)
  );

  rts_scaler #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_scl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (acq_end),
    .out_free (out_free),
    .cfg      (cfg_r),
    .raw      (raw),
    .stat     (stat),
    .screen_x (screen_x),
    .screen_y (screen_y)
  );

  // final tick's transaction is held back until the point is scaled
  assign load_tick = tick && !acq_end;
  assign load_fin  = stat.fin && out_free;

  always_comb begin
    out_data_nxt.chip_select_n = pins_nxt.cs_n;
    out_data_nxt.serial_clock  = pins_nxt.sclk;
    out_data_nxt.serial_din    = pins_nxt.din;
    out_data_nxt.point_done    = 1'b0;
    out_data_nxt.point_valid   = 1'b0;
    out_data_nxt.screen_x      = screen_x;
    out_data_nxt.screen_y      = screen_y;
    if (load_fin) begin
      out_data_nxt.chip_select_n = pins.cs_n;
      out_data_nxt.serial_clock  = pins.sclk;
      out_data_nxt.serial_din    = pins.din;
      out_data_nxt.point_done    = 1'b1;
      out_data_nxt.point_valid   = stat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_tick || load_fin) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_tick || load_fin) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
